### src/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared sizes and types for the LFU cache table: line storage layout and
// the result record of the line scan.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int ENTRIES    = 16;
	localparam int COUNT_BITS = 16;
	localparam int KEY_W      = 32;
	localparam int VAL_W      = 31;
	localparam int CAP_W      = 5;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W     = IDX_W;
	localparam int OCC_W      = $clog2(ENTRIES + 1);

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [RANK_W-1:0]     rank_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [KEY_W-1:0]      key_t;
	typedef logic [VAL_W-1:0]      val_t;

	// one line's bookkeeping word in the meta memory
	typedef struct packed {
		count_t count;
		rank_t  rank;
	} meta_t;

	// one line's payload word in the key/value memory
	typedef struct packed {
		key_t key;
		val_t value;
	} kv_t;

	// what the scan learned after visiting every line
	typedef struct packed {
		logic   hit;
		idx_t   hit_idx;
		rank_t  hit_rank;
		val_t   hit_value;
		logic   vic_found;
		idx_t   vic_idx;
		rank_t  vic_rank;
		count_t vic_count;
		logic   free_found;
		idx_t   free_idx;
	} scan_res_t;

endpackage

### src/lfu_scan.sv
// ----------------------------------------------------------------------------
// lfu_scan
// Visits one line per cycle while en is high and accumulates key match,
// LFU victim (oldest among minimum count) and the lowest free line.
// ----------------------------------------------------------------------------
module lfu_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              en,
	input  lfu_pkg::key_t     key,
	input  lfu_pkg::idx_t     line_idx,
	input  logic              line_valid,
	input  lfu_pkg::kv_t      line_kv,
	input  lfu_pkg::meta_t    line_meta,
	output lfu_pkg::scan_res_t res
);

	lfu_pkg::scan_res_t res_q;
	logic               take_victim;

	assign take_victim = line_valid && (!res_q.vic_found ||
		line_meta.count < res_q.vic_count ||
		(line_meta.count == res_q.vic_count && line_meta.rank > res_q.vic_rank));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q.hit        <= 1'b0;
			res_q.vic_found  <= 1'b0;
			res_q.free_found <= 1'b0;
		end else if (clear) begin
			res_q.hit        <= 1'b0;
			res_q.vic_found  <= 1'b0;
			res_q.free_found <= 1'b0;
		end else if (en) begin
			if (line_valid && !res_q.hit && line_kv.key == key) begin
				res_q.hit       <= 1'b1;
				res_q.hit_idx   <= line_idx;
				res_q.hit_rank  <= line_meta.rank;
				res_q.hit_value <= line_kv.value;
			end
			if (take_victim) begin
				res_q.vic_found <= 1'b1;
				res_q.vic_idx   <= line_idx;
				res_q.vic_rank  <= line_meta.rank;
				res_q.vic_count <= line_meta.count;
			end
			// keep the lowest-indexed free line
			if (!line_valid && !res_q.free_found) begin
				res_q.free_found <= 1'b1;
				res_q.free_idx   <= line_idx;
			end
		end
	end

	assign res = res_q;

endmodule

### src/lfu_cache_table_core.sv
// ----------------------------------------------------------------------------
// lfu_cache_table_core
// Fully associative key/value cache with LFU replacement and LRU tiebreak.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries func (0 get, 1 put),
//   lookup_key and write_value. Output channel (out_valid/out_ready)
//   returns one item per input item: hit, read_value, evicted.
//   cfg_wr_en/cfg_wr_data write capacity_in_use; write only while idle.
//   One item is in work at a time. Each item runs a search sweep over the
//   line memories through one read port (match, victim, free line); an
//   item that changes the store (hit, insert) then runs a read-modify-write
//   sweep that ages recency ranks and bumps use counts. A get miss or a put
//   at zero capacity skips the second sweep.
//   The writeback of line i lands while line i+1 is read, so no two
//   accesses hit the same entry and no forwarding is needed.
//   A finished item waits in the output register; the next input item is
//   accepted and worked on meanwhile, and holds in the result state only
//   while the output register is still full.
//   Reset: valid bits, occupancy and control clear at once, capacity goes
//   to 16. Key/value and meta memories need no clearing: their contents are
//   used only for valid lines.
// ----------------------------------------------------------------------------
module lfu_cache_table_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [lfu_pkg::CAP_W-1:0]         cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic signed [lfu_pkg::KEY_W-1:0]  lookup_key,
	input  logic [lfu_pkg::VAL_W-1:0]         write_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic [lfu_pkg::VAL_W-1:0]         read_value,
	output logic                              evicted
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SEARCH = 7'b0000010,
		ST_SDRAIN = 7'b0000100,
		ST_DECIDE = 7'b0001000,
		ST_UPDATE = 7'b0010000,
		ST_UDRAIN = 7'b0100000,
		ST_RESULT = 7'b1000000
	} state_t;

	localparam lfu_pkg::idx_t LAST_IDX = lfu_pkg::IDX_W'(lfu_pkg::ENTRIES - 1);

	state_t                          state_q;
	logic [lfu_pkg::CAP_W-1:0]       cap_q;
	logic [lfu_pkg::ENTRIES-1:0]     valid_q;
	logic [lfu_pkg::OCC_W-1:0]       occ_q;

	// latched item
	logic                            func_q;
	lfu_pkg::key_t                   key_q;
	lfu_pkg::val_t                   wval_q;

	// sweep address and read pipeline
	lfu_pkg::idx_t                   sweep_idx_q;
	logic                            rd_en;
	logic                            vld_s1;
	lfu_pkg::idx_t                   idx_s1;
	lfu_pkg::meta_t                  meta_rd_s1;
	lfu_pkg::kv_t                    kv_rd_s1;

	// memories
	lfu_pkg::meta_t                  meta_mem [lfu_pkg::ENTRIES];
	lfu_pkg::kv_t                    kv_mem   [lfu_pkg::ENTRIES];
	logic                            meta_we;
	lfu_pkg::meta_t                  meta_wdata;
	logic                            kv_we;
	lfu_pkg::kv_t                    kv_wdata;

	// scan
	lfu_pkg::scan_res_t              scan;
	logic                            scan_en;

	// decision, held for the update sweep
	logic                            ins_q;
	logic                            evict_q;
	lfu_pkg::idx_t                   target_q;
	lfu_pkg::rank_t                  ref_rank_q;

	logic                            dec_upd;
	logic                            dec_ins;
	logic                            dec_evict;
	lfu_pkg::idx_t                   dec_target;
	lfu_pkg::rank_t                  dec_rank;
	logic                            dec_hit;
	lfu_pkg::val_t                   dec_val;
	logic [31:0]                     eff_cap;
	logic                            full;

	// result waiting for output / output register
	logic                            res_hit_q;
	lfu_pkg::val_t                   res_val_q;
	logic                            res_evict_q;
	logic                            out_valid_q;
	logic                            out_hit_q;
	lfu_pkg::val_t                   out_val_q;
	logic                            out_evict_q;
	logic                            out_load;

	logic                            upd_en;
	logic                            is_tgt;
	lfu_pkg::count_t                 cnt_inc;

	assign in_ready = (state_q == ST_IDLE);
	assign rd_en    = (state_q == ST_SEARCH) || (state_q == ST_UPDATE);
	assign scan_en  = vld_s1 && ((state_q == ST_SEARCH) || (state_q == ST_SDRAIN));
	assign upd_en   = vld_s1 && ((state_q == ST_UPDATE) || (state_q == ST_UDRAIN));
	// move the finished item into the output register once it is free
	assign out_load = (state_q == ST_RESULT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[idx_s1] <= meta_wdata;
		end
		if (rd_en) begin
			meta_rd_s1 <= meta_mem[sweep_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (kv_we) begin
			kv_mem[dec_target] <= kv_wdata;
		end
		if (rd_en) begin
			kv_rd_s1 <= kv_mem[sweep_idx_q];
		end
	end

	lfu_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (in_valid && in_ready),
		.en         (scan_en),
		.key        (key_q),
		.line_idx   (idx_s1),
		.line_valid (valid_q[idx_s1]),
		.line_kv    (kv_rd_s1),
		.line_meta  (meta_rd_s1),
		.res        (scan)
	);

	// decide what the item does once the search sweep is complete
	always_comb begin
		eff_cap    = (32'(cap_q) > 32'(lfu_pkg::ENTRIES)) ? 32'(lfu_pkg::ENTRIES)
			: 32'(cap_q);
		full       = 32'(occ_q) >= eff_cap;
		dec_upd    = 1'b0;
		dec_ins    = 1'b0;
		dec_evict  = 1'b0;
		dec_target = scan.hit_idx;
		dec_rank   = scan.hit_rank;
		dec_hit    = 1'b0;
		dec_val    = '0;
		kv_we      = 1'b0;
		kv_wdata   = '{key: key_q, value: wval_q};
		if (!func_q) begin
			if (scan.hit) begin
				dec_upd = 1'b1;
				dec_hit = 1'b1;
				dec_val = scan.hit_value;
			end
		end else if (eff_cap != 32'd0) begin
			dec_upd = 1'b1;
			kv_we   = (state_q == ST_DECIDE);
			if (scan.hit) begin
				dec_hit = 1'b1;
			end else begin
				dec_ins = 1'b1;
				if (full && scan.vic_found) begin
					dec_evict  = 1'b1;
					dec_target = scan.vic_idx;
					dec_rank   = scan.vic_rank;
				end else begin
					dec_target = scan.free_idx;
				end
			end
		end
	end

	// rewrite one line's meta word during the update sweep
	always_comb begin
		is_tgt     = (idx_s1 == target_q);
		cnt_inc    = (meta_rd_s1.count == '1) ? meta_rd_s1.count
			: meta_rd_s1.count + lfu_pkg::COUNT_BITS'(1);
		meta_wdata = meta_rd_s1;
		if (is_tgt) begin
			meta_wdata.rank  = '0;
			meta_wdata.count = ins_q ? lfu_pkg::COUNT_BITS'(1) : cnt_inc;
		end else if (ins_q) begin
			// close the victim's rank gap, then age every line by one
			meta_wdata.rank = meta_rd_s1.rank + lfu_pkg::RANK_W'(1)
				- lfu_pkg::RANK_W'(evict_q && (meta_rd_s1.rank > ref_rank_q));
		end else if (meta_rd_s1.rank < ref_rank_q) begin
			meta_wdata.rank = meta_rd_s1.rank + lfu_pkg::RANK_W'(1);
		end
		meta_we = upd_en && (is_tgt || valid_q[idx_s1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= lfu_pkg::CAP_W'(16);
			valid_q     <= '0;
			occ_q       <= '0;
			vld_s1      <= 1'b0;
			sweep_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			vld_s1 <= rd_en;
			idx_s1 <= sweep_idx_q;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q      <= func;
						key_q       <= lookup_key;
						wval_q      <= write_value;
						sweep_idx_q <= '0;
						state_q     <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					sweep_idx_q <= sweep_idx_q + lfu_pkg::IDX_W'(1);
					if (sweep_idx_q == LAST_IDX) begin
						state_q <= ST_SDRAIN;
					end
				end
				ST_SDRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					ins_q       <= dec_ins;
					evict_q     <= dec_evict;
					target_q    <= dec_target;
					ref_rank_q  <= dec_rank;
					res_hit_q   <= dec_hit;
					res_val_q   <= dec_val;
					res_evict_q <= dec_evict;
					sweep_idx_q <= '0;
					// the victim line is reused, so occupancy grows only on a free insert
					if (dec_ins) begin
						valid_q[dec_target] <= 1'b1;
						if (!dec_evict) begin
							occ_q <= occ_q + lfu_pkg::OCC_W'(1);
						end
					end
					state_q <= dec_upd ? ST_UPDATE : ST_RESULT;
				end
				ST_UPDATE: begin
					sweep_idx_q <= sweep_idx_q + lfu_pkg::IDX_W'(1);
					if (sweep_idx_q == LAST_IDX) begin
						state_q <= ST_UDRAIN;
					end
				end
				ST_UDRAIN: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					// hold until the output register is free
					if (out_load) begin
						out_hit_q   <= res_hit_q;
						out_val_q   <= res_val_q;
						out_evict_q <= res_evict_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = out_hit_q;
	assign read_value = out_val_q;
	assign evicted    = out_evict_q;

endmodule

### sim/lfu_cache_table_core_tb.sv
// ----------------------------------------------------------------------------
// lfu_cache_table_core_tb
// Self-checking bench for the LFU cache table: a shadow copy of the cache
// predicts hit, read value and eviction for every accepted item. The bench
// runs directed corner cases, randomized traffic over several capacities and
// idle patterns, and a long output back-pressure stretch.
// ----------------------------------------------------------------------------
module lfu_cache_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 3000;
	localparam int EXP_DEPTH   = 64;

	typedef struct {
		logic hit;
		lfu_pkg::val_t rd;
		logic ev;
	} lookup_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [lfu_pkg::CAP_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = 1'b0;
	logic signed [lfu_pkg::KEY_W-1:0] lookup_key = '0;
	lfu_pkg::val_t write_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	lfu_pkg::val_t read_value;
	logic evicted;

	// shadow copy of the cache contents
	logic            sh_valid [lfu_pkg::ENTRIES];
	lfu_pkg::key_t   sh_key   [lfu_pkg::ENTRIES];
	lfu_pkg::val_t   sh_val   [lfu_pkg::ENTRIES];
	lfu_pkg::count_t sh_count [lfu_pkg::ENTRIES];
	int              sh_rank  [lfu_pkg::ENTRIES];
	int              sh_occ;
	int              sh_cap;

	// expected results, oldest at exp_rd
	lookup_res_t exp_fifo[EXP_DEPTH];
	int exp_wr = 0;
	int exp_rd = 0;
	lfu_pkg::key_t key_pool[24];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int recv_hold = 0;
	int idle_count = 0;
	bit failed = 0;

	lfu_cache_table_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .lookup_key(lookup_key), .write_value(write_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .read_value(read_value), .evicted(evicted)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Count one use of a line and move it to the front of the recency order.
	task automatic touch_line(input int t);
		for (int i = 0; i < lfu_pkg::ENTRIES; i++)
			if (sh_valid[i] && sh_rank[i] < sh_rank[t])
				sh_rank[i]++;
		sh_rank[t] = 0;
		if (sh_count[t] != '1)
			sh_count[t]++;
	endtask

	// Apply one operation to the shadow cache and return what the block must answer.
	task automatic cache_lookup(input logic f, input lfu_pkg::key_t k,
			input lfu_pkg::val_t v, output lookup_res_t r);
		int t, slot, eff_cap;
		r = '{1'b0, '0, 1'b0};
		eff_cap = (sh_cap > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES : sh_cap;
		t = -1;
		for (int i = 0; i < lfu_pkg::ENTRIES; i++)
			if (t < 0 && sh_valid[i] && sh_key[i] == k)
				t = i;
		if (f == 1'b0) begin
			if (t >= 0) begin
				touch_line(t);
				r.hit = 1'b1;
				r.rd = sh_val[t];
			end
			return;
		end
		// zero capacity: a put leaves everything alone, even on a present key
		if (eff_cap == 0)
			return;
		if (t >= 0) begin
			touch_line(t);
			sh_val[t] = v;
			r.hit = 1'b1;
			return;
		end
		slot = -1;
		if (sh_occ >= eff_cap) begin
			// lowest count wins, oldest line breaks the tie
			for (int i = 0; i < lfu_pkg::ENTRIES; i++)
				if (sh_valid[i] && (slot < 0 || sh_count[i] < sh_count[slot] ||
						(sh_count[i] == sh_count[slot] && sh_rank[i] > sh_rank[slot])))
					slot = i;
			if (slot >= 0) begin
				sh_valid[slot] = 1'b0;
				for (int i = 0; i < lfu_pkg::ENTRIES; i++)
					if (sh_valid[i] && sh_rank[i] > sh_rank[slot])
						sh_rank[i]--;
				sh_occ--;
				r.ev = 1'b1;
			end
		end
		if (slot < 0)
			for (int i = 0; i < lfu_pkg::ENTRIES; i++)
				if (slot < 0 && !sh_valid[i])
					slot = i;
		for (int i = 0; i < lfu_pkg::ENTRIES; i++)
			if (sh_valid[i])
				sh_rank[i]++;
		sh_valid[slot] = 1'b1;
		sh_key[slot] = k;
		sh_val[slot] = v;
		sh_count[slot] = 1;
		sh_rank[slot] = 0;
		sh_occ++;
	endtask

	// Offer one item; return just before the edge that accepts it.
	task automatic send_item(input logic f, input lfu_pkg::key_t k, input lfu_pkg::val_t v);
		int gaps;
		lookup_res_t r;
		gaps = 0;
		while (gaps < 30 && $urandom_range(99) < send_idle_pct)
			gaps++;
		@(posedge clk);
		if (gaps > 0) begin
			in_valid <= 1'b0;
			repeat (gaps) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		lookup_key <= k;
		write_value <= v;
		forever begin
			@(negedge clk);
			if (in_ready)
				break;
			@(posedge clk);
		end
		cache_lookup(f, k, v, r);
		exp_fifo[exp_wr % EXP_DEPTH] = r;
		exp_wr++;
	endtask

	// Drop valid, then hold until every expected result has come back.
	task automatic drain;
		@(posedge clk);
		in_valid <= 1'b0;
		wait (exp_wr == exp_rd);
		repeat (45) @(posedge clk);
	endtask

	task automatic set_capacity(input int c);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c[lfu_pkg::CAP_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sh_cap = c;
	endtask

	function automatic lfu_pkg::key_t pick_key();
		if ($urandom_range(9) == 0)
			return $urandom();
		return key_pool[$urandom_range(23)];
	endfunction

	function automatic lfu_pkg::val_t pick_value();
		case ($urandom_range(7))
			0: return '1;
			1: return '0;
			default: return lfu_pkg::val_t'($urandom());
		endcase
	endfunction

	task automatic test_directed;
		set_capacity(16);
		send_item(1'b0, 32'h0000_0000, '1);        // get miss on empty store
		send_item(1'b1, 32'h8000_0000, '1);        // extreme keys and values
		send_item(1'b1, 32'h7FFF_FFFF, '0);
		send_item(1'b1, 32'hFFFF_FFFF, 31'h2AAA_AAAA);
		send_item(1'b0, 32'h8000_0000, '0);        // get hit
		send_item(1'b1, 32'h7FFF_FFFF, 31'h5555_5555); // put on present key
		send_item(1'b0, 32'h7FFF_FFFF, '0);
		// fill the store, then force an eviction of the coldest, oldest line
		for (int i = 0; i < 14; i++)
			send_item(1'b1, lfu_pkg::key_t'(i), lfu_pkg::val_t'(i * 7));
		send_item(1'b1, 32'h1234_5678, 31'h0BAD_CAFE);
		send_item(1'b0, 32'hFFFF_FFFF, '0);
		// zero capacity ignores a put even on a present key
		set_capacity(0);
		send_item(1'b1, 32'h8000_0000, 31'h1);
		send_item(1'b0, 32'h8000_0000, '0);
		// capacity above the line count acts as full size
		set_capacity(31);
		send_item(1'b1, 32'h0BAD_0000, 31'h3);
		// shrink below occupancy: each insert evicts exactly one line
		set_capacity(2);
		send_item(1'b1, 32'h0BAD_0001, 31'h4);
		send_item(1'b1, 32'h0BAD_0002, 31'h5);
		send_item(1'b0, 32'h0BAD_0001, '0);
	endtask

	task automatic test_random;
		int caps[8] = '{16, 1, 4, 0, 31, 8, 2, 12};
		int idle_mode[4][2] = '{'{0, 0}, '{60, 0}, '{0, 60}, '{34, 34}};
		for (int ph = 0; ph < 8; ph++) begin
			set_capacity(caps[ph]);
			send_idle_pct = idle_mode[ph % 4][0];
			recv_stall_pct = idle_mode[ph % 4][1];
			for (int n = 0; n < 205; n++)
				send_item(1'(($urandom_range(99) < 45)), pick_key(), pick_value());
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// Hold the output off for a long stretch while items keep coming.
	task automatic test_backpressure;
		set_capacity(6);
		recv_hold = 300;
		for (int n = 0; n < 12; n++)
			send_item(1'(n % 2), key_pool[n % 8], pick_value());
		drain();
	endtask

	// receiver: random stalls, or a counted hold-off when one is requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (recv_hold > 0) begin
			out_ready <= 1'b0;
			recv_hold--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare each accepted result against the oldest expectation
	always @(negedge clk) begin
		lookup_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (exp_wr == exp_rd) begin
				$display("%t unexpected result hit=%0b read_value=%h evicted=%0b",
					$realtime, hit, read_value, evicted);
				failed = 1;
			end else begin
				e = exp_fifo[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (hit !== e.hit) begin
					$display("%t hit expected %0b actual %0b", $realtime, e.hit, hit);
					failed = 1;
				end
				if (read_value !== e.rd) begin
					$display("%t read_value expected %h actual %h",
						$realtime, e.rd, read_value);
					failed = 1;
				end
				if (evicted !== e.ev) begin
					$display("%t evicted expected %0b actual %0b",
						$realtime, e.ev, evicted);
					failed = 1;
				end
			end
		end
	end

	// watchdog: reset while either channel moves items, else count up
	always @(negedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_count = 0;
		else
			idle_count++;
		if (idle_count > STALL_LIMIT) begin
			$display("[lfu_cache_table_core] ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
			sh_valid[i] = 1'b0;
			sh_count[i] = '0;
			sh_rank[i] = 0;
			sh_key[i] = '0;
			sh_val[i] = '0;
		end
		sh_occ = 0;
		sh_cap = 16;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = 32'h7FFF_FFFF;
		for (int i = 4; i < 24; i++)
			key_pool[i] = $urandom();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random();
		test_backpressure();
		drain();
		if (!failed)
			$display("[lfu_cache_table_core] OK");
		else
			$display("[lfu_cache_table_core] ERROR");
		$finish;
	end

endmodule
